/* rtl/core/bsp_pkg.sv */
// Shared types, constants and elaboration helpers for the Bezier surface evaluator.
// No dependencies; imported by bsp_basis, bsp_grid and bezier_surface_point_eval.
package bsp_pkg;

  // fixed-point formats
  localparam int FRAC_BITS  = 16;
  localparam int Q_ONE      = 65536;
  localparam int ROUND_HALF = 32768;
  localparam int POS_W      = 17;          // unsigned Q1.16 parameter and power product
  localparam int IDX_W      = 8;           // sample index
  localparam int RES_W      = 9;           // resolution register
  localparam int DEG_REG_W  = 3;           // degree registers
  localparam int GRID_IDX_W = 3;           // row and col fields of a load
  localparam int COORD_W    = 32;          // stored and returned coordinate width
  localparam int NUM_W      = IDX_W + FRAC_BITS;

  // stream payload widths
  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 96;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = RES_W;
  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE_U   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE_V   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESOLUTION = 2'd2;
  localparam logic [DEG_REG_W-1:0] DEGREE_RESET     = 3'd3;
  localparam logic [RES_W-1:0]     RESOLUTION_RESET = 9'd16;

  // request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  typedef struct packed {
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } point_t;

  typedef struct packed {
    logic [GRID_IDX_W-1:0] row;
    logic [GRID_IDX_W-1:0] col;
    point_t                point;
  } load_t;

  // binomial coefficient by Pascal's triangle, elaboration only
  function automatic int binom(input int n, input int k);
    int row_c [0:31];
    for (int r = 0; r < 32; r++) row_c[r] = 0;
    row_c[0] = 1;
    for (int r = 1; r <= n; r++) begin
      for (int c = r; c >= 1; c--) row_c[c] = row_c[c] + row_c[c-1];
    end
    if (k > n) return 0;
    return row_c[k];
  endfunction

  // width of one basis value C(n,i) * p
  function automatic int basis_width(input int max_degree);
    return POS_W + $clog2(binom(max_degree, max_degree / 2) + 1);
  endfunction

endpackage

/* rtl/core/bsp_basis.sv */
// One-direction Bernstein basis unit: parameter divider, power chain and binomial scaling.
// Depends on bsp_pkg; one shared 17x17 multiplier does every product.
module bsp_basis import bsp_pkg::*; #(
  parameter int MAX_DEGREE = 7,
  localparam int GRID_SIDE = MAX_DEGREE + 1,
  localparam int DEG_W     = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1,
  localparam int B_W       = basis_width(MAX_DEGREE)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [IDX_W-1:0] idx,
  input  logic [RES_W-1:0] den,
  input  logic [DEG_W-1:0] n,
  output logic             done,
  output logic [B_W-1:0]   b [GRID_SIDE]
);

  localparam int BIN_W = B_W - POS_W;
  localparam int CNT_W = $clog2(NUM_W);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_POW  = 2'd2;
  localparam logic [1:0] ST_BAS  = 2'd3;

  logic [1:0]         st;
  logic [CNT_W-1:0]   cnt;
  logic [NUM_W-1:0]   quo;
  logic [RES_W-1:0]   rem;
  logic [RES_W-1:0]   dvs;
  logic [DEG_W-1:0]   nsel;
  logic [DEG_W-1:0]   k;
  logic [DEG_W-1:0]   i;
  logic [DEG_W-1:0]   rem_s;
  logic [POS_W-1:0]   t_val;
  logic [POS_W-1:0]   s_val;
  logic [POS_W-1:0]   p;
  logic [POS_W-1:0]   tp [GRID_SIDE];
  logic [BIN_W-1:0]   binom_tab [GRID_SIDE][GRID_SIDE];

  logic [RES_W:0]     rem_sh;
  logic               ge;
  logic [RES_W-1:0]   rem_nx;
  logic [NUM_W-1:0]   quo_nx;
  logic [IDX_W-1:0]   idx_eff;
  logic [POS_W-1:0]   mul_b;
  logic [2*POS_W-1:0] prod;
  logic [2*POS_W-1:0] prod_r;
  logic [POS_W-1:0]   rnd;

  // binomial coefficients as a constant table
  for (genvar gn = 0; gn < GRID_SIDE; gn++) begin : g_bn
    for (genvar gk = 0; gk < GRID_SIDE; gk++) begin : g_bk
      assign binom_tab[gn][gk] = BIN_W'(binom(gn, gk));
    end
  end

  // index clamped to the last sample
  assign idx_eff = ({1'b0, idx} > den) ? den[IDX_W-1:0] : idx;

  // restoring division step, one quotient bit a cycle
  assign rem_sh = {rem, quo[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs};
  assign rem_nx = ge ? RES_W'(rem_sh - {1'b0, dvs}) : rem_sh[RES_W-1:0];
  assign quo_nx = {quo[NUM_W-2:0], ge};

  // shared multiplier with Q16 rounding
  always_comb begin
    if (st == ST_POW) begin
      mul_b = t_val;
    end else if (rem_s != '0) begin
      mul_b = s_val;
    end else begin
      mul_b = POS_W'(binom_tab[nsel][i]);
    end
  end
  assign prod   = p * mul_b;
  assign prod_r = prod + (2*POS_W)'(ROUND_HALF);
  assign rnd    = prod_r[FRAC_BITS +: POS_W];

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= ST_IDLE;
      done <= 1'b0;
    end else begin
      unique case (st)
        ST_IDLE: begin
          if (start) begin
            st   <= ST_DIV;
            done <= 1'b0;
          end
        end
        ST_DIV: begin
          if (cnt == CNT_W'(NUM_W - 1)) st <= ST_POW;
        end
        ST_POW: begin
          if (k == nsel) st <= ST_BAS;
        end
        ST_BAS: begin
          if (rem_s == '0 && i == nsel) begin
            st   <= ST_IDLE;
            done <= 1'b1;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (st)
      ST_IDLE: begin
        if (start) begin
          quo  <= {idx_eff, FRAC_BITS'(den[RES_W-1:1])};
          rem  <= '0;
          dvs  <= den;
          cnt  <= '0;
          nsel <= n;
        end
      end
      ST_DIV: begin
        quo <= quo_nx;
        rem <= rem_nx;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          t_val <= quo_nx[POS_W-1:0];
          s_val <= POS_W'(Q_ONE) - quo_nx[POS_W-1:0];
          p     <= POS_W'(Q_ONE);
          tp[0] <= POS_W'(Q_ONE);
          k     <= DEG_W'(1);
        end
      end
      ST_POW: begin
        tp[k] <= rnd;
        if (k == nsel) begin
          p     <= POS_W'(Q_ONE);
          i     <= '0;
          rem_s <= nsel;
        end else begin
          p <= rnd;
          k <= k + 1'b1;
        end
      end
      ST_BAS: begin
        if (rem_s != '0) begin
          p     <= rnd;
          rem_s <= rem_s - 1'b1;
        end else begin
          b[i] <= B_W'(prod);
          if (i != nsel) begin
            i     <= i + 1'b1;
            p     <= tp[i + 1'b1];
            rem_s <= nsel - i - 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/bsp_grid.sv */
// Control-point memory with the weight and accumulate pipeline and output rounding.
// Depends on bsp_pkg; basis rows come from two bsp_basis units.
module bsp_grid import bsp_pkg::*; #(
  parameter int MAX_DEGREE  = 7,
  parameter int COORD_WIDTH = 32,
  localparam int GRID_SIDE = MAX_DEGREE + 1,
  localparam int DEG_W     = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1,
  localparam int B_W       = basis_width(MAX_DEGREE)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  load_t            wr,
  input  logic             start,
  input  logic [DEG_W-1:0] nu,
  input  logic [DEG_W-1:0] nv,
  input  logic [B_W-1:0]   bu [GRID_SIDE],
  input  logic [B_W-1:0]   bv [GRID_SIDE],
  output logic             done,
  output point_t           result
);

  localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W     = $clog2(GRID_CELLS);
  localparam int WP_W       = 2 * B_W;
  localparam int W_W        = WP_W - FRAC_BITS;
  localparam int TERM_W     = COORD_W + W_W + 1;
  localparam int ACC_W      = TERM_W + ADDR_W;
  localparam int R_W        = ACC_W - FRAC_BITS;
  localparam int SAT_W      = ((R_W > COORD_WIDTH) ? R_W : COORD_WIDTH) + 1;
  localparam logic signed [SAT_W-1:0] SAT_HI =
    (SAT_W'(1) <<< (COORD_WIDTH - 1)) - SAT_W'(1);
  localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(1);

  point_t                   mem [GRID_CELLS];
  point_t                   rdata;
  logic                     run;
  logic [DEG_W-1:0]         gi;
  logic [DEG_W-1:0]         gj;
  logic                     last0;
  logic [ADDR_W-1:0]        raddr;
  logic [WP_W-1:0]          wprod;
  logic [WP_W-1:0]          wsum;
  logic [W_W-1:0]           w;
  logic                     v1, l1, v2, l2;
  logic signed [TERM_W-1:0] tx, ty, tz;
  logic signed [ACC_W-1:0]  acc_x, acc_y, acc_z;

  // rounding and saturation of one accumulated coordinate
  function automatic logic [COORD_W-1:0] finish_coord(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] sr;
    logic signed [R_W-1:0]   r;
    logic signed [SAT_W-1:0] re;
    logic signed [SAT_W-1:0] sat;
    sr = a + ACC_W'(ROUND_HALF);
    r  = sr[ACC_W-1:FRAC_BITS];
    re = SAT_W'(r);
    if (re > SAT_HI) sat = SAT_HI;
    else if (re < SAT_LO) sat = SAT_LO;
    else sat = re;
    return sat[COORD_W-1:0];
  endfunction

  // control-point memory, loads write one entry
  always_ff @(posedge clk) begin
    if (wr_en && int'(wr.row) < GRID_SIDE && int'(wr.col) < GRID_SIDE) begin
      mem[ADDR_W'(int'(wr.row) * GRID_SIDE + int'(wr.col))] <= wr.point;
    end
    rdata <= mem[raddr];
  end

  assign raddr = ADDR_W'(int'(gi) * GRID_SIDE + int'(gj));
  assign last0 = (gi == nu) && (gj == nv);

  // issue one grid entry a cycle, row by row
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      v1  <= 1'b0;
      v2  <= 1'b0;
    end else begin
      v1 <= run;
      v2 <= v1;
      if (start) begin
        run <= 1'b1;
      end else if (run && last0) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      gi <= '0;
      gj <= '0;
    end else if (run) begin
      if (gj == nv) begin
        gj <= '0;
        gi <= gi + 1'b1;
      end else begin
        gj <= gj + 1'b1;
      end
    end
    wprod <= bu[gi] * bv[gj];
    l1    <= run && last0;
    l2    <= l1;
  end

  // weight rounding then coordinate products
  assign wsum = wprod + WP_W'(ROUND_HALF);
  assign w    = wsum[WP_W-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    tx <= $signed(rdata.x) * $signed({1'b0, w});
    ty <= $signed(rdata.y) * $signed({1'b0, w});
    tz <= $signed(rdata.z) * $signed({1'b0, w});
  end

  // exact accumulation
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else if (start) begin
      done <= 1'b0;
    end else if (v2 && l2) begin
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_x <= '0;
      acc_y <= '0;
      acc_z <= '0;
    end else if (v2) begin
      acc_x <= acc_x + ACC_W'(tx);
      acc_y <= acc_y + ACC_W'(ty);
      acc_z <= acc_z + ACC_W'(tz);
    end
  end

  assign result.x = finish_coord(acc_x);
  assign result.y = finish_coord(acc_y);
  assign result.z = finish_coord(acc_z);

endmodule

/* rtl/core/bezier_surface_point_eval.sv */
// Top level of the tensor-product Bezier surface point evaluator.
// Depends on bsp_pkg, bsp_basis (two instances, u and v) and bsp_grid.
//
//  channel   | dir | handshake               | payload
//  s_axis    | in  | s_axis_tvalid/tready    | tdata: row,col,x,y,z,u_index,v_index; tuser
//  m_axis    | out | m_axis_tvalid/tready    | tdata: x_out,y_out,z_out
//  cfg       | in  | cfg_wr_en               | cfg_addr, cfg_wdata
//
// A load item writes one grid entry. An evaluate item first computes the basis rows
// (u and v run in parallel, each using the 24-step divider and the basis unit's single
// multiplier), then reads the (nu+1)(nv+1) grid entries from memory one entry a
// cycle, then passes the result to the output register.
// Reset clears control state and loads the register defaults; the grid is not cleared.
// Input is taken only while no evaluation is in flight; a waiting result holds the
// block in its final step until the output register is free.
module bezier_surface_point_eval import bsp_pkg::*; #(
  parameter int MAX_DEGREE  = 7,
  parameter int COORD_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // row[2:0], col[5:3], x_in[37:6], y_in[69:38], z_in[101:70],
  // u_index[109:102], v_index[117:110], zero pad [119:118]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // req_type
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // x_out[31:0], y_out[63:32], z_out[95:64]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int GRID_SIDE = MAX_DEGREE + 1;
  localparam int DEG_W     = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int B_W       = basis_width(MAX_DEGREE);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_BASIS = 2'd1;
  localparam logic [1:0] ST_MAC   = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]           state;
  logic [DEG_REG_W-1:0] degree_u;
  logic [DEG_REG_W-1:0] degree_v;
  logic [RES_W-1:0]     resolution;
  logic [DEG_W-1:0]     nu, nv;
  logic [RES_W-1:0]     den;
  logic                 in_acc;
  logic                 eval_start;
  logic                 g_start;
  logic                 u_done, v_done, g_done;
  logic                 out_free;
  logic [B_W-1:0]       bu [GRID_SIDE];
  logic [B_W-1:0]       bv [GRID_SIDE];
  load_t                ld;
  point_t               g_result;
  logic [IDX_W-1:0]     u_index, v_index;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      degree_u   <= DEGREE_RESET;
      degree_v   <= DEGREE_RESET;
      resolution <= RESOLUTION_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_DEGREE_U:   degree_u   <= cfg_wdata[DEG_REG_W-1:0];
        CFG_DEGREE_V:   degree_v   <= cfg_wdata[DEG_REG_W-1:0];
        CFG_RESOLUTION: resolution <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective degrees and parameter divisor
  always_comb begin
    if (degree_u == '0) nu = DEG_W'(1);
    else if (int'(degree_u) > MAX_DEGREE) nu = DEG_W'(MAX_DEGREE);
    else nu = DEG_W'(degree_u);
    if (degree_v == '0) nv = DEG_W'(1);
    else if (int'(degree_v) > MAX_DEGREE) nv = DEG_W'(MAX_DEGREE);
    else nv = DEG_W'(degree_v);
    den = (resolution < RES_W'(2)) ? RES_W'(1) : resolution - RES_W'(1);
  end

  // input unpacking
  assign ld.row     = s_axis_tdata[2:0];
  assign ld.col     = s_axis_tdata[5:3];
  assign ld.point.x = s_axis_tdata[37:6];
  assign ld.point.y = s_axis_tdata[69:38];
  assign ld.point.z = s_axis_tdata[101:70];
  assign u_index    = s_axis_tdata[109:102];
  assign v_index    = s_axis_tdata[117:110];

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign eval_start    = in_acc && (s_axis_tuser == REQ_EVAL);
  assign g_start       = (state == ST_BASIS) && u_done && v_done;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  bsp_basis #(.MAX_DEGREE(MAX_DEGREE)) u_basis_u (
    .clk   (clk),
    .rst   (rst),
    .start (eval_start),
    .idx   (u_index),
    .den   (den),
    .n     (nu),
    .done  (u_done),
    .b     (bu)
  );

  bsp_basis #(.MAX_DEGREE(MAX_DEGREE)) u_basis_v (
    .clk   (clk),
    .rst   (rst),
    .start (eval_start),
    .idx   (v_index),
    .den   (den),
    .n     (nv),
    .done  (v_done),
    .b     (bv)
  );

  bsp_grid #(.MAX_DEGREE(MAX_DEGREE), .COORD_WIDTH(COORD_WIDTH)) u_grid (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (in_acc && (s_axis_tuser == REQ_LOAD)),
    .wr     (ld),
    .start  (g_start),
    .nu     (nu),
    .nv     (nv),
    .bu     (bu),
    .bv     (bv),
    .done   (g_done),
    .result (g_result)
  );

  // evaluation sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE:  if (eval_start) state <= ST_BASIS;
        ST_BASIS: if (g_start) state <= ST_MAC;
        ST_MAC:   if (g_done) state <= ST_FIN;
        ST_FIN:   if (out_free) state <= ST_IDLE;
        default:  state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      m_axis_tdata <= g_result;
    end
  end

`ifndef SYNTH
  // a new result only appears out of the final sequencer step
  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == ST_FIN)
    else $error("result raised outside final step");

  // basis rows stay valid while the grid accumulates
  a_basis_held: assert property (@(posedge clk) disable iff (rst)
    state == ST_MAC |-> u_done && v_done)
    else $error("basis row lost during accumulation");

  // accumulation finishes only while the sequencer waits for it
  a_done_in_mac: assert property (@(posedge clk) disable iff (rst)
    $rose(g_done) |-> state == ST_MAC)
    else $error("grid finished outside accumulation");

  // a free output slot in the final step always yields a result
  a_fin_delivers: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN && out_free |=> m_axis_tvalid && state == ST_IDLE)
    else $error("final step did not deliver");
`endif

endmodule
